/* design/fqatan_pkg.sv */
package fqatan_pkg;

  // default output scale
  localparam int ANGLE_FRAC_BITS_DEF = 29;

  // field and working widths
  localparam int IN_W     = 32;
  localparam int MAG_W    = 32;
  localparam int SHIFT_W  = 6;
  localparam int POS_W    = 5;
  localparam int C_W      = 61;
  localparam int Z_W      = 62;
  localparam int M_W      = 62;
  localparam int OUT_W    = 32;

  // normalization target and iteration count
  localparam int NORM_MSB     = 57;
  localparam int WORK_BITS    = 60;
  localparam int CORDIC_STEPS = 60;

  // pi in q60
  localparam logic [63:0]    PI_Q60  = 64'h3243F6A8885A308D;
  localparam logic [M_W-1:0] PI_M    = PI_Q60[M_W-1:0];
  localparam logic [M_W-1:0] HALF_PI = PI_Q60[M_W:1];

  // quadrant and special-case flags that ride along the pipe
  typedef struct packed {
    logic yneg;
    logic xneg;
    logic ax_zero;
    logic ay_zero;
  } flags_t;

  // truncating divide of a power of two by the odd number 2k+1
  function automatic logic [63:0] odd_div(input logic [63:0] p, input int unsigned k);
    logic [63:0] q;
    case (k)
      0:       q = p / 64'd1;
      1:       q = p / 64'd3;
      2:       q = p / 64'd5;
      3:       q = p / 64'd7;
      4:       q = p / 64'd9;
      5:       q = p / 64'd11;
      6:       q = p / 64'd13;
      7:       q = p / 64'd15;
      8:       q = p / 64'd17;
      9:       q = p / 64'd19;
      10:      q = p / 64'd21;
      11:      q = p / 64'd23;
      12:      q = p / 64'd25;
      13:      q = p / 64'd27;
      14:      q = p / 64'd29;
      15:      q = p / 64'd31;
      16:      q = p / 64'd33;
      17:      q = p / 64'd35;
      18:      q = p / 64'd37;
      19:      q = p / 64'd39;
      20:      q = p / 64'd41;
      21:      q = p / 64'd43;
      22:      q = p / 64'd45;
      23:      q = p / 64'd47;
      24:      q = p / 64'd49;
      25:      q = p / 64'd51;
      26:      q = p / 64'd53;
      27:      q = p / 64'd55;
      28:      q = p / 64'd57;
      29:      q = p / 64'd59;
      default: q = '0;
    endcase
    return q;
  endfunction

  // atan(2^-i) in q60 from a truncated taylor series
  function automatic logic [Z_W-1:0] rot_angle(input int unsigned i);
    logic [63:0] sum;
    logic [63:0] t;
    int unsigned k;
    int unsigned e;
    sum = '0;
    if (i == 0) begin
      sum = PI_Q60 >> 2;
    end else begin
      for (k = 0; k < 30; k++) begin
        e = (2 * k + 1) * i;
        if (e <= WORK_BITS) begin
          t = odd_div(64'd1 << (WORK_BITS - e), k);
          if (k[0]) begin
            sum = sum - t;
          end else begin
            sum = sum + t;
          end
        end
      end
    end
    return sum[Z_W-1:0];
  endfunction

endpackage

/* design/four_quadrant_arctangent_unit.sv */
// channel   | direction | handshake          | payload
// in_       | input     | in_valid/in_stall   | in_y_in, in_x_in (signed 32)
// out_      | output    | out_valid/out_stall | out_angle (signed q3.frac), out_invalid
//
// one request per cycle while the pipe is not stalled; 3 prep stages (fold, shift search,
// normalize), one stage per each of the 60 cordic micro-rotations, 4 finish stages.
// rst_n is synchronous, active low, and clears the valid bits only.
// out_stall freezes the whole pipe while a result waits; in_stall follows it.
module four_quadrant_arctangent_unit #(
  parameter int ANGLE_FRAC_BITS = fqatan_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [fqatan_pkg::IN_W-1:0]  in_y_in,
  input  logic signed [fqatan_pkg::IN_W-1:0]  in_x_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [fqatan_pkg::OUT_W-1:0] out_angle,
  output logic                                out_invalid
);

  localparam int N = fqatan_pkg::CORDIC_STEPS;

  logic                              en;
  logic                              v_s  [0:N];
  logic signed [fqatan_pkg::C_W-1:0] cx_s [0:N];
  logic signed [fqatan_pkg::C_W-1:0] cy_s [0:N];
  logic signed [fqatan_pkg::Z_W-1:0] z_s  [0:N];
  fqatan_pkg::flags_t                fl_s [0:N];

  // pipe advances unless a finished result is held
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // fold, shift search, normalize
  fqatan_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (in_valid),
    .y_i     (in_y_in),
    .x_i     (in_x_in),
    .valid_o (v_s[0]),
    .cx_o    (cx_s[0]),
    .cy_o    (cy_s[0]),
    .flags_o (fl_s[0])
  );

  assign z_s[0] = '0;

  // cordic rotation chain
  for (genvar g = 0; g < N; g++) begin : g_rot
    fqatan_cordic_stage #(
      .STAGE (g)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (v_s[g]),
      .cx_i    (cx_s[g]),
      .cy_i    (cy_s[g]),
      .z_i     (z_s[g]),
      .flags_i (fl_s[g]),
      .valid_o (v_s[g+1]),
      .cx_o    (cx_s[g+1]),
      .cy_o    (cy_s[g+1]),
      .z_o     (z_s[g+1]),
      .flags_o (fl_s[g+1])
    );
  end

  // clamp, quadrant, rounding, output register
  fqatan_post #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .valid_i   (v_s[N]),
    .z_i       (z_s[N]),
    .flags_i   (fl_s[N]),
    .valid_o   (out_valid),
    .angle_o   (out_angle),
    .invalid_o (out_invalid)
  );

`ifndef SYNTHESIS
  // zero pair reports angle zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid |-> out_angle == '0)
    else $error("invalid result with nonzero angle");

  // angle stays within rounded +-pi
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ($signed(out_angle) <= $signed(32'((fqatan_pkg::PI_Q60 +
         (64'd1 << (fqatan_pkg::WORK_BITS - ANGLE_FRAC_BITS - 1))) >>
         (fqatan_pkg::WORK_BITS - ANGLE_FRAC_BITS)))) &&
      ($signed(out_angle) >= -$signed(32'((fqatan_pkg::PI_Q60 +
         (64'd1 << (fqatan_pkg::WORK_BITS - ANGLE_FRAC_BITS - 1))) >>
         (fqatan_pkg::WORK_BITS - ANGLE_FRAC_BITS)))))
    else $error("angle outside -pi..pi");
`endif

endmodule

/* design/fqatan_prep.sv */
module fqatan_prep (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                valid_i,
  input  logic signed [fqatan_pkg::IN_W-1:0]  y_i,
  input  logic signed [fqatan_pkg::IN_W-1:0]  x_i,
  output logic                                valid_o,
  output logic signed [fqatan_pkg::C_W-1:0]   cx_o,
  output logic signed [fqatan_pkg::C_W-1:0]   cy_o,
  output fqatan_pkg::flags_t                  flags_o
);

  // stage a: magnitudes and flags
  logic                              va_r;
  logic [fqatan_pkg::MAG_W-1:0]      ax_a_r, ax_a_nxt;
  logic [fqatan_pkg::MAG_W-1:0]      ay_a_r, ay_a_nxt;
  fqatan_pkg::flags_t                fl_a_r, fl_a_nxt;

  // stage b: normalizing shift
  logic                              vb_r;
  logic [fqatan_pkg::MAG_W-1:0]      ax_b_r, ay_b_r;
  logic [fqatan_pkg::SHIFT_W-1:0]    sh_b_r, sh_b_nxt;
  fqatan_pkg::flags_t                fl_b_r;
  logic [fqatan_pkg::MAG_W-1:0]      m_b;
  logic [fqatan_pkg::POS_W-1:0]      pos_b;

  // stage c: normalized operands
  logic                              vc_r;
  logic signed [fqatan_pkg::C_W-1:0] cx_c_r, cx_c_nxt;
  logic signed [fqatan_pkg::C_W-1:0] cy_c_r, cy_c_nxt;
  fqatan_pkg::flags_t                fl_c_r;

  // fold signs, -2^31 keeps its true magnitude
  always_comb begin
    fl_a_nxt.yneg    = y_i[fqatan_pkg::IN_W-1];
    fl_a_nxt.xneg    = x_i[fqatan_pkg::IN_W-1];
    fl_a_nxt.ay_zero = (y_i == '0);
    fl_a_nxt.ax_zero = (x_i == '0);
    ay_a_nxt = y_i[fqatan_pkg::IN_W-1] ? (fqatan_pkg::MAG_W'(0) - $unsigned(y_i))
                                      : $unsigned(y_i);
    ax_a_nxt = x_i[fqatan_pkg::IN_W-1] ? (fqatan_pkg::MAG_W'(0) - $unsigned(x_i))
                                      : $unsigned(x_i);
  end

  // msb of the larger magnitude sets the shift
  always_comb begin
    m_b   = (ax_a_r > ay_a_r) ? ax_a_r : ay_a_r;
    pos_b = '0;
    for (int b = 0; b < fqatan_pkg::MAG_W; b++) begin
      if (m_b[b]) begin
        pos_b = fqatan_pkg::POS_W'(b);
      end
    end
    sh_b_nxt = fqatan_pkg::SHIFT_W'(fqatan_pkg::NORM_MSB) - {1'b0, pos_b};
  end

  // scale both operands up
  always_comb begin
    cx_c_nxt = $signed({{(fqatan_pkg::C_W-fqatan_pkg::MAG_W){1'b0}}, ax_b_r} << sh_b_r);
    cy_c_nxt = $signed({{(fqatan_pkg::C_W-fqatan_pkg::MAG_W){1'b0}}, ay_b_r} << sh_b_r);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (en) begin
      va_r <= valid_i;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      ax_a_r <= ax_a_nxt;
      ay_a_r <= ay_a_nxt;
      fl_a_r <= fl_a_nxt;
      ax_b_r <= ax_a_r;
      ay_b_r <= ay_a_r;
      sh_b_r <= sh_b_nxt;
      fl_b_r <= fl_a_r;
      cx_c_r <= cx_c_nxt;
      cy_c_r <= cy_c_nxt;
      fl_c_r <= fl_b_r;
    end
  end

  assign valid_o = vc_r;
  assign cx_o    = cx_c_r;
  assign cy_o    = cy_c_r;
  assign flags_o = fl_c_r;

endmodule

/* design/fqatan_cordic_stage.sv */
module fqatan_cordic_stage #(
  parameter int STAGE = 0
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              valid_i,
  input  logic signed [fqatan_pkg::C_W-1:0] cx_i,
  input  logic signed [fqatan_pkg::C_W-1:0] cy_i,
  input  logic signed [fqatan_pkg::Z_W-1:0] z_i,
  input  fqatan_pkg::flags_t                flags_i,
  output logic                              valid_o,
  output logic signed [fqatan_pkg::C_W-1:0] cx_o,
  output logic signed [fqatan_pkg::C_W-1:0] cy_o,
  output logic signed [fqatan_pkg::Z_W-1:0] z_o,
  output fqatan_pkg::flags_t                flags_o
);

  localparam logic signed [fqatan_pkg::Z_W-1:0] ROT = fqatan_pkg::rot_angle(STAGE);

  logic                              valid_r;
  logic signed [fqatan_pkg::C_W-1:0] cx_r, cx_nxt;
  logic signed [fqatan_pkg::C_W-1:0] cy_r, cy_nxt;
  logic signed [fqatan_pkg::Z_W-1:0] z_r, z_nxt;
  fqatan_pkg::flags_t                flags_r;
  logic signed [fqatan_pkg::C_W-1:0] dx, dy;

  // one vectoring micro-rotation, direction from the sign of y
  always_comb begin
    dx = cy_i >>> STAGE;
    dy = cx_i >>> STAGE;
    if (!cy_i[fqatan_pkg::C_W-1]) begin
      cx_nxt = cx_i + dx;
      cy_nxt = cy_i - dy;
      z_nxt  = z_i + ROT;
    end else begin
      cx_nxt = cx_i - dx;
      cy_nxt = cy_i + dy;
      z_nxt  = z_i - ROT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r    <= cx_nxt;
      cy_r    <= cy_nxt;
      z_r     <= z_nxt;
      flags_r <= flags_i;
    end
  end

  assign valid_o = valid_r;
  assign cx_o    = cx_r;
  assign cy_o    = cy_r;
  assign z_o     = z_r;
  assign flags_o = flags_r;

endmodule

/* design/fqatan_post.sv */
module fqatan_post #(
  parameter int ANGLE_FRAC_BITS = fqatan_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                valid_i,
  input  logic signed [fqatan_pkg::Z_W-1:0]   z_i,
  input  fqatan_pkg::flags_t                  flags_i,
  output logic                                valid_o,
  output logic signed [fqatan_pkg::OUT_W-1:0] angle_o,
  output logic                                invalid_o
);

  localparam int SH = fqatan_pkg::WORK_BITS - ANGLE_FRAC_BITS;
  localparam logic [fqatan_pkg::M_W:0] RND = (fqatan_pkg::M_W + 1)'(1) << (SH - 1);

  // stage a: clamped first-quadrant angle
  logic                           va_r;
  logic [fqatan_pkg::M_W-1:0]     th_a_r, th_a_nxt;
  fqatan_pkg::flags_t             fl_a_r;

  // stage b: quadrant-corrected magnitude
  logic                           vb_r;
  logic [fqatan_pkg::M_W-1:0]     mag_b_r, mag_b_nxt;
  fqatan_pkg::flags_t             fl_b_r;

  // stage c: rounded magnitude
  logic                           vc_r;
  logic [fqatan_pkg::OUT_W-1:0]   rnd_c_r, rnd_c_nxt;
  logic                           neg_c_r, inv_c_r;
  logic [fqatan_pkg::M_W:0]       sum_c, shf_c;

  // stage d: output register
  logic                              vd_r;
  logic signed [fqatan_pkg::OUT_W-1:0] angle_d_r, angle_d_nxt;
  logic                              inv_d_r;

  // clamp residue to [0, pi/2], zero ordinate gives zero
  always_comb begin
    if (z_i[fqatan_pkg::Z_W-1]) begin
      th_a_nxt = '0;
    end else if ($unsigned(z_i) > fqatan_pkg::HALF_PI) begin
      th_a_nxt = fqatan_pkg::HALF_PI;
    end else begin
      th_a_nxt = $unsigned(z_i);
    end
    if (flags_i.ay_zero) begin
      th_a_nxt = '0;
    end
  end

  // restore the quadrant
  always_comb begin
    if (fl_a_r.ax_zero) begin
      mag_b_nxt = fqatan_pkg::HALF_PI;
    end else if (fl_a_r.xneg) begin
      mag_b_nxt = fqatan_pkg::PI_M - th_a_r;
    end else begin
      mag_b_nxt = th_a_r;
    end
  end

  // round to nearest at the output scale
  always_comb begin
    sum_c     = {1'b0, mag_b_r} + RND;
    shf_c     = sum_c >> SH;
    rnd_c_nxt = shf_c[fqatan_pkg::OUT_W-1:0];
  end

  // apply sign, zero pair gives zero
  always_comb begin
    if (inv_c_r) begin
      angle_d_nxt = '0;
    end else if (neg_c_r) begin
      angle_d_nxt = $signed(fqatan_pkg::OUT_W'(0) - rnd_c_r);
    end else begin
      angle_d_nxt = $signed(rnd_c_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else if (en) begin
      va_r <= valid_i;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      th_a_r    <= th_a_nxt;
      fl_a_r    <= flags_i;
      mag_b_r   <= mag_b_nxt;
      fl_b_r    <= fl_a_r;
      rnd_c_r   <= rnd_c_nxt;
      neg_c_r   <= fl_b_r.yneg;
      inv_c_r   <= fl_b_r.ax_zero & fl_b_r.ay_zero;
      angle_d_r <= angle_d_nxt;
      inv_d_r   <= inv_c_r;
    end
  end

  assign valid_o   = vd_r;
  assign angle_o   = angle_d_r;
  assign invalid_o = inv_d_r;

endmodule
